// File: design/tmr_pkg.sv
// Shared types and constants for the thruster mixer with round-robin refresh.
// No dependencies; imported by tmr_mix and thruster_mix_and_refresh.
`default_nettype none

package tmr_pkg;

  localparam int MAX_ENGINES = 8;
  localparam int PTR_W       = $clog2(MAX_ENGINES);
  localparam int SRV_W       = $clog2(MAX_ENGINES + 1);
  localparam int ENG_IDX_W   = 3;
  localparam int SPEED_W     = 8;
  localparam int SETP_W      = 9;
  localparam int MIX_W       = SETP_W + 1;
  localparam int FUNC_W      = 3;
  localparam int PACE_W      = 16;
  localparam int EC_W        = 4;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 16;

  localparam int MIN_SERVED    = 3;
  localparam int SPEED_LIMIT   = 255;
  localparam int EC_RESET      = 3;
  localparam int INTERVAL_RESET = 20;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK     = 3'd0,
    FUNC_VERTICAL = 3'd1,
    FUNC_MOVE     = 3'd2,
    FUNC_ROTATE   = 3'd3,
    FUNC_HALT     = 3'd4,
    FUNC_START    = 3'd5,
    FUNC_STOP     = 3'd6
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENGINE_COUNT     = 1'd0,
    REG_REVERSE_INTERVAL = 1'd1
  } cfg_reg_t;

  typedef enum logic {
    CMD_SPEED   = 1'b0,
    CMD_REVERSE = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    logic                rev;
    logic [SPEED_W-1:0]  speed;
  } tgt_t;

  typedef tgt_t [MAX_ENGINES-1:0] tgt_arr_t;

  typedef struct packed {
    logic signed [SETP_W-1:0] vert;
    logic signed [SETP_W-1:0] move;
    logic signed [SETP_W-1:0] rot;
    logic                     halt;
    logic                     on;
  } setp_t;

  // An entry takes a mix result only when it lies within the speed range.
  function automatic tgt_t put_speed(input logic signed [MIX_W-1:0] s, input tgt_t cur);
    tgt_t res;
    res = cur;
    if (s >= -MIX_W'(SPEED_LIMIT) && s < 0) begin
      res.speed = SPEED_W'(-s);
      res.rev   = 1'b1;
    end else if (s >= 0 && s <= MIX_W'(SPEED_LIMIT)) begin
      res.speed = SPEED_W'(s);
      res.rev   = 1'b0;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: design/thruster_mix_and_refresh.sv
// Top level of the thruster mixer with round-robin command refresh.
// Depends on tmr_pkg and tmr_mix.
`default_nettype none

// The block accepts one transaction per clock cycle unless a tick is held in
// the input register. An accepted item goes into the input register, where
// setpoint updates and the remix of all engine targets are applied; a tick
// there produces one command for the output register, which drives out_tvalid.
// Only a full output register that is not being taken holds off a tick; other
// items never wait on the output side. Configuration is taken at any time but
// should be written only while the block is idle.
module thruster_mix_and_refresh
  import tmr_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_tvalid,
  output      logic                    in_tready,
  input  wire logic [IN_DATA_W-1:0]    in_tdata,   // value[8:0]
  input  wire logic [FUNC_W-1:0]       in_tuser,   // func[2:0]
  output      logic                    out_tvalid,
  input  wire logic                    out_tready,
  output      logic [OUT_DATA_W-1:0]   out_tdata,  // engine_index[2:0], cmd_value[10:3]
  output      logic                    out_tuser,  // cmd_kind[0]
  input  wire logic                    cfg_valid,
  output      logic                    cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data
);

  logic                      s1_valid_r;
  logic [FUNC_W-1:0]         s1_func_r;
  logic signed [SETP_W-1:0]  s1_value_r;

  logic [EC_W-1:0]           engine_count_r;
  logic [PACE_W-1:0]         interval_r;
  setp_t                     setp_r, setp_nxt;
  tgt_arr_t                  tgt_r, tgt_nxt, tgt_mix;
  logic [PTR_W-1:0]          ptr_r, ptr_nxt;
  logic [PACE_W-1:0]         pace_r, pace_nxt;

  logic                      out_valid_r;
  cmd_kind_t                 out_kind_r, out_kind_nxt;
  logic [ENG_IDX_W-1:0]      out_eng_r;
  logic [SPEED_W-1:0]        out_value_r, out_value_nxt;

  logic [SRV_W-1:0]          served;
  logic [PTR_W:0]            ptr_inc;
  logic [PACE_W-1:0]         pace_inc;
  logic                      is_tick;
  logic                      do_remix;
  logic                      out_free;
  logic                      proc;

  always_comb begin
    if (EC_W'(engine_count_r) < EC_W'(MIN_SERVED)) begin
      served = SRV_W'(MIN_SERVED);
    end else if (32'(engine_count_r) > MAX_ENGINES) begin
      served = SRV_W'(MAX_ENGINES);
    end else begin
      served = SRV_W'(engine_count_r);
    end
  end

  assign is_tick   = (s1_func_r == FUNC_TICK);
  assign out_free  = !out_valid_r || out_tready;
  assign proc      = s1_valid_r && (!is_tick || out_free);
  assign in_tready = !s1_valid_r || proc;
  assign cfg_ready = 1'b1;

  always_comb begin
    setp_nxt = setp_r;
    do_remix = 1'b1;
    unique case (s1_func_r)
      FUNC_VERTICAL: setp_nxt.vert = s1_value_r;
      FUNC_MOVE:     setp_nxt.move = s1_value_r;
      FUNC_ROTATE:   setp_nxt.rot  = s1_value_r;
      FUNC_HALT:     setp_nxt.halt = s1_value_r[0];
      FUNC_START:    setp_nxt.on   = 1'b1;
      FUNC_STOP:     setp_nxt.on   = 1'b0;
      default:       do_remix      = 1'b0;
    endcase
  end

  tmr_mix u_mix (
    .setp    (setp_nxt),
    .served  (served),
    .tgt_cur (tgt_r),
    .tgt_mix (tgt_mix)
  );

  assign tgt_nxt = do_remix ? tgt_mix : tgt_r;

  always_comb begin
    if (ptr_r <= PTR_W'(1) && pace_r != '1) begin
      pace_inc = pace_r + PACE_W'(1);
    end else begin
      pace_inc = pace_r;
    end
    ptr_inc = {1'b0, ptr_r} + (PTR_W+1)'(1);
    if (32'(ptr_inc) >= 32'(served)) begin
      ptr_nxt = '0;
    end else begin
      ptr_nxt = ptr_inc[PTR_W-1:0];
    end
    if (pace_inc >= interval_r) begin
      pace_nxt      = '0;
      out_kind_nxt  = CMD_REVERSE;
      out_value_nxt = {{(SPEED_W-1){1'b0}}, tgt_r[ptr_nxt].rev};
    end else begin
      pace_nxt      = pace_inc;
      out_kind_nxt  = CMD_SPEED;
      out_value_nxt = tgt_r[ptr_nxt].speed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      engine_count_r <= EC_W'(EC_RESET);
      interval_r     <= PACE_W'(INTERVAL_RESET);
      setp_r         <= '{vert: '0, move: '0, rot: '0, halt: 1'b0, on: 1'b1};
      tgt_r          <= '0;
      ptr_r          <= '0;
      pace_r         <= '0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_ENGINE_COUNT:     engine_count_r <= cfg_data[EC_W-1:0];
          REG_REVERSE_INTERVAL: interval_r     <= cfg_data[PACE_W-1:0];
          default: ;
        endcase
      end
      if (proc) begin
        setp_r <= setp_nxt;
        tgt_r  <= tgt_nxt;
        if (is_tick) begin
          ptr_r  <= ptr_nxt;
          pace_r <= pace_nxt;
        end
      end
      if (proc && is_tick) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_func_r  <= in_tuser;
      s1_value_r <= in_tdata[SETP_W-1:0];
    end
    if (proc && is_tick) begin
      out_kind_r  <= out_kind_nxt;
      out_eng_r   <= ENG_IDX_W'(ptr_nxt);
      out_value_r <= out_value_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {(OUT_DATA_W-ENG_IDX_W-SPEED_W)'(0), out_value_r, out_eng_r};

endmodule

`default_nettype wire

// File: design/tmr_mix.sv
// Combinational remix of the per-engine speed and direction targets.
// Depends on tmr_pkg for the setpoint and target types.
`default_nettype none

module tmr_mix
  import tmr_pkg::*;
(
  input  wire setp_t              setp,
  input  wire logic [SRV_W-1:0]   served,
  input  wire tgt_arr_t           tgt_cur,
  output tgt_arr_t                tgt_mix
);

  logic signed [MIX_W-1:0] mv;
  logic signed [MIX_W-1:0] rt;
  logic signed [MIX_W-1:0] vt;

  assign mv = {setp.move[SETP_W-1], setp.move};
  assign rt = {setp.rot[SETP_W-1], setp.rot};
  assign vt = {setp.vert[SETP_W-1], setp.vert};

  always_comb begin
    tgt_mix    = tgt_cur;
    tgt_mix[0] = put_speed(vt, tgt_cur[0]);
    if (!setp.on) begin
      for (int i = 0; i < MAX_ENGINES; i++) begin
        if (SRV_W'(i) < served) begin
          tgt_mix[i] = '0;
        end
      end
    end else if (setp.halt) begin
      tgt_mix[1] = put_speed(rt, tgt_cur[1]);
      tgt_mix[2] = put_speed(-rt, tgt_cur[2]);
    end else if (!rt[MIX_W-1]) begin
      tgt_mix[1] = put_speed(mv - rt, tgt_cur[1]);
      tgt_mix[2] = put_speed(mv, tgt_cur[2]);
    end else begin
      tgt_mix[1] = put_speed(mv, tgt_cur[1]);
      tgt_mix[2] = put_speed(mv + rt, tgt_cur[2]);
    end
  end

endmodule

`default_nettype wire
